/* design/assert_macros.svh */
// Assertion macros used by the keyed entry table datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KET_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define KET_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ket_pkg.sv */
// Shared types and constants of the keyed entry table.
`default_nettype none

package ket_pkg;

	localparam int ID_W     = 64;
	localparam int KEY_W    = 64;
	localparam int CFG_W    = 7;
	localparam int STATUS_W = 2;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	// Item actions.
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

	// One table entry as stored in memory.
	typedef struct packed {
		logic [ID_W-1:0]  client;
		logic [ID_W-1:0]  server;
		logic [KEY_W-1:0] key;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic load;
		logic scan;
		logic commit;
	} ket_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic scan_done;
	} ket_stat_t;

endpackage

`default_nettype wire

/* design/ket_ctrl.sv */
// Controller state machine of the keyed entry table.
`default_nettype none

module ket_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire ket_pkg::ket_stat_t stat,
	output ket_pkg::ket_cmd_t       cmd,
	output logic                    busy
);

	localparam logic [1:0] S_CLEAR  = 2'd0;
	localparam logic [1:0] S_IDLE   = 2'd1;
	localparam logic [1:0] S_SCAN   = 2'd2;
	localparam logic [1:0] S_COMMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.scan_done) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Commands to the datapath.
	always_comb begin
		cmd.clear  = (state_q == S_CLEAR);
		cmd.load   = (state_q == S_IDLE) && start;
		cmd.scan   = (state_q == S_SCAN);
		cmd.commit = (state_q == S_COMMIT);
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

/* design/ket_datapath.sv */
// Datapath of the keyed entry table: entry memory, scan counter, compare and result.
`default_nettype none
`include "assert_macros.svh"

module ket_datapath #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire ket_pkg::ket_cmd_t                cmd,
	output ket_pkg::ket_stat_t                    stat,
	input  wire                                   cfg_we,
	input  wire  [ket_pkg::CFG_W-1:0]             cfg_data,
	input  wire                                   action,
	input  wire  [ket_pkg::ID_W-1:0]              client_id,
	input  wire  [ket_pkg::ID_W-1:0]              server_id,
	input  wire  [ket_pkg::KEY_W-1:0]             key_data,
	output logic                                  done,
	output logic [ket_pkg::STATUS_W-1:0]          status,
	output logic [ket_pkg::KEY_W-1:0]            read_key
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// Entry memory, one row per slot.
	ket_pkg::entry_t mem [TABLE_DEPTH];

	logic [ket_pkg::CFG_W-1:0] cfg_q;
	logic [CNT_W-1:0]          span_d;
	logic [CNT_W-1:0]          span_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      action_q;
	logic [ket_pkg::ID_W-1:0]  cid_q;
	logic [ket_pkg::ID_W-1:0]  sid_q;
	logic [ket_pkg::KEY_W-1:0] key_q;

	ket_pkg::entry_t           rdata_s1;
	logic [IDX_W-1:0]          rd_idx_s1;
	logic                      rd_valid_s1;

	logic                      match_found_q;
	logic [IDX_W-1:0]          match_idx_q;
	logic [ket_pkg::KEY_W-1:0] match_key_q;
	logic                      empty_found_q;
	logic [IDX_W-1:0]          empty_idx_q;

	logic                      issue;
	logic                      exhausted;
	logic                      hit_now;
	logic                      empty_now;
	logic                      wr_en;
	logic [IDX_W-1:0]          wr_addr;
	ket_pkg::entry_t           wr_data;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ket_pkg::CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_data;
		end
	end

	// Search length saturates at the table depth.
	always_comb begin
		if (int'(cfg_q) > TABLE_DEPTH) begin
			span_d = CNT_W'(TABLE_DEPTH);
		end else begin
			span_d = CNT_W'(cfg_q);
		end
	end

	// Compare the entry read last cycle against the latched id pair and against an all-zero entry.
	assign hit_now   = rd_valid_s1 && (rdata_s1.client == cid_q) && (rdata_s1.server == sid_q);
	assign empty_now = rd_valid_s1 && (rdata_s1.client == '0) && (rdata_s1.server == '0)
		&& (rdata_s1.key == '0);
	assign exhausted = (cnt_q >= span_q);
	assign issue     = cmd.scan && !exhausted && !hit_now;

	assign stat.scan_done  = cmd.scan && (hit_now || (exhausted && !rd_valid_s1));
	assign stat.clear_last = (cnt_q == CNT_W'(TABLE_DEPTH - 1));

	// Slot counter: clearing sweep after reset, then read address of each scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.clear || issue) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Latch the accepted item and its search length.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			cid_q    <= client_id;
			sid_q    <= server_id;
			key_q    <= key_data;
			span_q   <= span_d;
		end
	end

	// Read-valid flag of the registered memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
		end
	end

	// Registered memory read.
	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1  <= mem[cnt_q[IDX_W-1:0]];
			rd_idx_s1 <= cnt_q[IDX_W-1:0];
		end
	end

	// Track the first matching slot and the first empty slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			empty_found_q <= 1'b0;
		end else if (cmd.load) begin
			match_found_q <= 1'b0;
			empty_found_q <= 1'b0;
		end else begin
			if (hit_now) begin
				match_found_q <= 1'b1;
			end
			if (empty_now) begin
				empty_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit_now) begin
			match_idx_q <= rd_idx_s1;
			match_key_q <= rdata_s1.key;
		end
		if (empty_now && !empty_found_q) begin
			empty_idx_q <= rd_idx_s1;
		end
	end

	// Memory write port: clearing sweep or committed write.
	always_comb begin
		wr_en = cmd.clear || (cmd.commit && (action_q == ket_pkg::ACT_WRITE)
			&& (match_found_q || empty_found_q));
		if (cmd.clear) begin
			wr_addr = cnt_q[IDX_W-1:0];
			wr_data = '0;
		end else begin
			wr_addr = match_found_q ? match_idx_q : empty_idx_q;
			wr_data.client = cid_q;
			wr_data.server = sid_q;
			wr_data.key    = key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.commit;
		end
	end

	// Result payload; the key is zero on every write and on a miss.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (action_q == ket_pkg::ACT_WRITE) begin
				status   <= (match_found_q || empty_found_q) ? ket_pkg::ST_OK : ket_pkg::ST_FULL;
				read_key <= '0;
			end else if (match_found_q) begin
				status   <= ket_pkg::ST_OK;
				read_key <= match_key_q;
			end else begin
				status   <= ket_pkg::ST_NOT_FOUND;
				read_key <= '0;
			end
		end
	end

	`KET_ASSERT_NOW(a_read_in_span, clk, arst_n, rd_valid_s1, CNT_W'(rd_idx_s1) < span_q, "scan read beyond the search length")
	`KET_ASSERT_NXT(a_done_after_commit, clk, arst_n, cmd.commit, done, "commit did not produce a result")
	`KET_ASSERT_NOW(a_full_has_no_key, clk, arst_n, done && (status != ket_pkg::ST_OK), read_key == '0, "failed item carries a nonzero key")

endmodule

`default_nettype wire

/* design/keyed_entry_table_unit.sv */
// Top level of the keyed entry table: controller, datapath and configuration port.
// Each item scans the first n slots, n being entries_in_use capped at TABLE_DEPTH, and a
// hit on slot k ends the scan at that slot; the result comes with done.
// One item at a time: a new start is taken only when idle (busy until done).
// Reset: the table is cleared by a sweep over all TABLE_DEPTH slots with busy high;
// configuration writes are taken at any time. The receiver cannot stall results.
`default_nettype none

module keyed_entry_table_unit #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [ket_pkg::CFG_W-1:0]        cfg_data,
	input  wire                              start,
	output logic                             busy,
	input  wire                              action,
	input  wire  [ket_pkg::ID_W-1:0]         client_id,
	input  wire  [ket_pkg::ID_W-1:0]         server_id,
	input  wire  [ket_pkg::KEY_W-1:0]        key_data,
	output logic                             done,
	output logic [ket_pkg::STATUS_W-1:0]     status,
	output logic [ket_pkg::KEY_W-1:0]        read_key
);

	ket_pkg::ket_cmd_t  cmd;
	ket_pkg::ket_stat_t stat;

	// The register is always writable.
	assign cfg_ready = 1'b1;

	ket_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	ket_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.action    (action),
		.client_id (client_id),
		.server_id (server_id),
		.key_data  (key_data),
		.done      (done),
		.status    (status),
		.read_key  (read_key)
	);

endmodule

`default_nettype wire

/* bench/tb_keyed_entry_table_unit.sv */
// Self-checking bench for the keyed entry table: directed rows, then random lookups and updates.
module tb_keyed_entry_table_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ID_W = ket_pkg::ID_W;
	localparam int KEY_W = ket_pkg::KEY_W;
	localparam int CFG_W = ket_pkg::CFG_W;
	localparam int STATUS_W = ket_pkg::STATUS_W;

	localparam int TABLE_DEPTH = 64;
	localparam logic [ID_W-1:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int RANDOM_PHASES = 9;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int PHASE_SPAN [RANDOM_PHASES] = '{64, 3, 127, 1, 0, 17, 64, 2, 40};

	// One result as the block reports it.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    read_key;
	} answer_t;

	typedef enum logic {ROW_ITEM, ROW_SPAN} row_kind_t;

	// One row of the directed table; for a span row the new span sits in cid.
	typedef struct {
		row_kind_t        kind;
		logic             act;
		logic [ID_W-1:0]  cid;
		logic [ID_W-1:0]  sid;
		logic [KEY_W-1:0] kd;
		bit               typed;
		answer_t          ans;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_data = '0;
	logic                start = 1'b0;
	logic                busy;
	logic                action = ket_pkg::ACT_WRITE;
	logic [ID_W-1:0]     client_id = '0;
	logic [ID_W-1:0]     server_id = '0;
	logic [KEY_W-1:0]    key_data = '0;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [KEY_W-1:0]    read_key;

	// Shadow copy of the table and of the span register.
	logic [ID_W-1:0]  shadow_client [TABLE_DEPTH];
	logic [ID_W-1:0]  shadow_server [TABLE_DEPTH];
	logic [KEY_W-1:0] shadow_key [TABLE_DEPTH];
	logic [CFG_W-1:0] shadow_span;

	answer_t   expected_answers [$];
	stim_row_t directed_rows [$];
	int        n_fail = 0;

	keyed_entry_table_unit #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.action(action),
		.client_id(client_id),
		.server_id(server_id),
		.key_data(key_data),
		.done(done),
		.status(status),
		.read_key(read_key)
	);

	always #1 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Linear search over the active span: update a matching pair, else fill the first
	// empty slot, else report full; a read returns the first matching key.
	function automatic answer_t predict_lookup(logic act, logic [ID_W-1:0] cid,
			logic [ID_W-1:0] sid, logic [KEY_W-1:0] kd);
		answer_t ans;
		int n;
		int slot;
		n = (int'(shadow_span) > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_span);
		slot = -1;
		ans.status = ket_pkg::ST_OK;
		ans.read_key = '0;
		for (int i = 0; i < n; i++) begin
			if (slot < 0 && shadow_client[i] == cid && shadow_server[i] == sid)
				slot = i;
		end
		if (act == ket_pkg::ACT_WRITE) begin
			for (int i = 0; i < n; i++) begin
				if (slot < 0 && shadow_client[i] == '0 && shadow_server[i] == '0
						&& shadow_key[i] == '0)
					slot = i;
			end
			if (slot >= 0) begin
				shadow_client[slot] = cid;
				shadow_server[slot] = sid;
				shadow_key[slot] = kd;
			end else begin
				ans.status = ket_pkg::ST_FULL;
			end
		end else begin
			if (slot >= 0)
				ans.read_key = shadow_key[slot];
			else
				ans.status = ket_pkg::ST_NOT_FOUND;
		end
		return ans;
	endfunction

	function automatic void add_row(row_kind_t kind, logic act, logic [ID_W-1:0] cid,
			logic [ID_W-1:0] sid, logic [KEY_W-1:0] kd, bit typed,
			logic [STATUS_W-1:0] st, logic [KEY_W-1:0] rk);
		stim_row_t r;
		r.kind = kind;
		r.act = act;
		r.cid = cid;
		r.sid = sid;
		r.kd = kd;
		r.typed = typed;
		r.ans.status = st;
		r.ans.read_key = rk;
		directed_rows.push_back(r);
	endfunction

	// Present one item and hold it until the block takes it.
	task automatic send_item(logic act, logic [ID_W-1:0] cid, logic [ID_W-1:0] sid,
			logic [KEY_W-1:0] kd, bit typed, answer_t typed_ans);
		answer_t ans;
		@(negedge clk);
		start <= 1'b1;
		action <= act;
		client_id <= cid;
		server_id <= sid;
		key_data <= kd;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		ans = predict_lookup(act, cid, sid, kd);
		expected_answers.push_back(typed ? typed_ans : ans);
	endtask

	// Drop start and wait until every outstanding item has answered.
	task automatic wait_all_answered();
		@(negedge clk);
		start <= 1'b0;
		while (expected_answers.size() != 0)
			@(posedge clk);
	endtask

	// Random sender gap, roughly pct cycles out of a hundred.
	task automatic sender_gap(int pct);
		if ($urandom_range(99) < pct) begin
			@(negedge clk);
			start <= 1'b0;
			while ($urandom_range(99) < pct)
				@(negedge clk);
		end
	endtask

	// Change the span only with the block idle.
	task automatic set_span(logic [CFG_W-1:0] v);
		wait_all_answered();
		repeat (2) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		shadow_span = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result checker: every strobe must match the oldest expectation.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				$error("result with nothing expected: status=%0d read_key=%h", status, read_key);
				n_fail++;
			end else begin
				want = expected_answers.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					n_fail++;
				end
				if (read_key !== want.read_key) begin
					$error("read_key: expected %h, got %h", want.read_key, read_key);
					n_fail++;
				end
			end
		end
	end

	initial begin
		logic             act;
		logic [ID_W-1:0]  c;
		logic [ID_W-1:0]  s;
		logic [KEY_W-1:0] k;
		logic [ID_W-1:0]  pool_cid [16];
		logic [ID_W-1:0]  pool_sid [16];
		int               pick;
		int               p;
		int               idle_pct;

		for (int i = 0; i < TABLE_DEPTH; i++) begin
			shadow_client[i] = '0;
			shadow_server[i] = '0;
			shadow_key[i] = '0;
		end
		shadow_span = ket_pkg::CFG_RESET;
		for (int i = 0; i < 16; i++) begin
			pool_cid[i] = rand64();
			pool_sid[i] = rand64();
		end

		// Directed rows: empty table, extremes, update, zero pair, full and span limits.
		add_row(ROW_ITEM, ket_pkg::ACT_READ, 1, 2, 0, 1, ket_pkg::ST_NOT_FOUND, 0);
		add_row(ROW_ITEM, ket_pkg::ACT_READ, 0, 0, ONES, 1, ket_pkg::ST_OK, 0);
		add_row(ROW_ITEM, ket_pkg::ACT_WRITE, ONES, ONES, ONES, 1, ket_pkg::ST_OK, 0);
		add_row(ROW_ITEM, ket_pkg::ACT_READ, ONES, ONES, 0, 1, ket_pkg::ST_OK, ONES);
		add_row(ROW_ITEM, ket_pkg::ACT_WRITE, ONES, ONES, 64'hA5A5_A5A5_A5A5_A5A5, 1,
			ket_pkg::ST_OK, 0);
		add_row(ROW_ITEM, ket_pkg::ACT_READ, ONES, ONES, ONES, 1,
			ket_pkg::ST_OK, 64'hA5A5_A5A5_A5A5_A5A5);
		add_row(ROW_ITEM, ket_pkg::ACT_WRITE, 0, 0, 0, 1, ket_pkg::ST_OK, 0);
		add_row(ROW_ITEM, ket_pkg::ACT_WRITE, 0, 0, 64'h1234, 1, ket_pkg::ST_OK, 0);
		add_row(ROW_ITEM, ket_pkg::ACT_READ, 0, 0, 0, 1, ket_pkg::ST_OK, 64'h1234);
		add_row(ROW_SPAN, ket_pkg::ACT_WRITE, 2, 0, 0, 0, ket_pkg::ST_OK, 0);
		add_row(ROW_ITEM, ket_pkg::ACT_WRITE, 1, 1, 1, 1, ket_pkg::ST_FULL, 0);
		add_row(ROW_ITEM, ket_pkg::ACT_READ, 1, 1, 0, 1, ket_pkg::ST_NOT_FOUND, 0);
		add_row(ROW_SPAN, ket_pkg::ACT_WRITE, 0, 0, 0, 0, ket_pkg::ST_OK, 0);
		add_row(ROW_ITEM, ket_pkg::ACT_WRITE, ONES, ONES, 7, 1, ket_pkg::ST_FULL, 0);
		add_row(ROW_ITEM, ket_pkg::ACT_READ, ONES, ONES, 0, 1, ket_pkg::ST_NOT_FOUND, 0);
		add_row(ROW_SPAN, ket_pkg::ACT_WRITE, 127, 0, 0, 0, ket_pkg::ST_OK, 0);
		add_row(ROW_ITEM, ket_pkg::ACT_WRITE, 1, 1, 1, 1, ket_pkg::ST_OK, 0);
		add_row(ROW_ITEM, ket_pkg::ACT_READ, 1, 1, 0, 1, ket_pkg::ST_OK, 1);
		add_row(ROW_SPAN, ket_pkg::ACT_WRITE, 1, 0, 0, 0, ket_pkg::ST_OK, 0);
		add_row(ROW_ITEM, ket_pkg::ACT_READ, 1, 1, 0, 1, ket_pkg::ST_NOT_FOUND, 0);
		add_row(ROW_ITEM, ket_pkg::ACT_WRITE, ONES, 0, 64'hAAAA_AAAA_AAAA_AAAA, 1,
			ket_pkg::ST_FULL, 0);
		add_row(ROW_ITEM, ket_pkg::ACT_WRITE, ONES, ONES, 0, 1, ket_pkg::ST_OK, 0);
		add_row(ROW_SPAN, ket_pkg::ACT_WRITE, 64, 0, 0, 0, ket_pkg::ST_OK, 0);
		add_row(ROW_ITEM, ket_pkg::ACT_READ, 1, 1, 0, 1, ket_pkg::ST_OK, 1);
		add_row(ROW_ITEM, ket_pkg::ACT_WRITE, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
			64'h3C3C_3C3C_3C3C_3C3C, 0, ket_pkg::ST_OK, 0);
		add_row(ROW_ITEM, ket_pkg::ACT_READ, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
			0, 0, ket_pkg::ST_OK, 0);
		add_row(ROW_ITEM, ket_pkg::ACT_READ, ONES, ONES, 0, 1, ket_pkg::ST_OK, 0);

		// Single reset at the start of the run.
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_SPAN)
				set_span(directed_rows[i].cid[CFG_W-1:0]);
			else
				send_item(directed_rows[i].act, directed_rows[i].cid, directed_rows[i].sid,
					directed_rows[i].kd, directed_rows[i].typed, directed_rows[i].ans);
		end

		// Random phases: sender idles at 25, then 72, then 0 cycles in a hundred.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_span(CFG_W'(PHASE_SPAN[ph]));
			idle_pct = (ph < 3) ? 25 : (ph < 6) ? 72 : 0;
			for (int it = 0; it < ITEMS_PER_PHASE; it++) begin
				pick = $urandom_range(99);
				k = ($urandom_range(19) == 0) ? '0 : rand64();
				if (pick < 10) begin
					// Zero pair, often with a zero key so a slot becomes empty again.
					c = '0;
					s = '0;
					if ($urandom_range(1) == 0)
						k = '0;
				end else if (pick < 25) begin
					c = rand64();
					s = rand64();
				end else if (pick < 30) begin
					// Client matches a known pair, server does not.
					p = $urandom_range(15);
					c = pool_cid[p];
					s = rand64();
				end else begin
					p = ($urandom_range(1) == 0) ? $urandom_range(3) : $urandom_range(15);
					c = pool_cid[p];
					s = pool_sid[p];
				end
				act = 1'($urandom_range(1));
				if ($urandom_range(49) == 0)
					wait_all_answered();
				sender_gap(idle_pct);
				send_item(act, c, s, k, 1'b0, '0);
			end
		end

		wait_all_answered();
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (expected_answers.size() != 0) begin
			$error("%0d expected results never arrived", expected_answers.size());
			n_fail++;
		end
		if (n_fail == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
